// ===== design/mmld_pkg.sv =====
// shared types, constants and codes for the masked max l1 distance search
package mmld_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int SERVER_COUNT    = 20;
    localparam int FEATURE_COUNT   = 4;

    localparam int FEAT_W     = 7;
    localparam int FEAT_SLOTS = 4;
    localparam int ID_W       = 16;
    localparam int MASK_W     = 20;
    localparam int SRV_W      = 5;
    localparam int DIST_W     = 9;
    localparam int FUNC_W     = 2;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    typedef logic [FEAT_SLOTS-1:0][FEAT_W-1:0] t_feats;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        t_feats            feats;
        logic [MASK_W-1:0] seen;
        logic              bad;
    } t_entry;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        REG_FEAT_A = 2'd0,
        REG_FEAT_B = 2'd1,
        REG_FEAT_C = 2'd2,
        REG_FEAT_D = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// ===== design/mmld_table.sv =====
// task table memory, one write port and one registered read port
module mmld_table
    import mmld_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/mmld_dist.sv =====
// l1 distance between an entry's features and the current features
module mmld_dist
    import mmld_pkg::*;
(
    input  t_feats            i_cur,
    input  t_feats            i_feats,
    output logic [DIST_W-1:0] o_dist
);

    logic [DIST_W-1:0] sum;

    always_comb begin
        sum = '0;
        for (int k = 0; k < FEATURE_COUNT; k++) begin
            if (i_cur[k] > i_feats[k]) begin
                sum = sum + DIST_W'(i_cur[k] - i_feats[k]);
            end else begin
                sum = sum + DIST_W'(i_feats[k] - i_cur[k]);
            end
        end
    end

    assign o_dist = sum;

endmodule

// ===== design/masked_max_l1_distance_search.sv =====
// top level: task table, scan sequencer, current feature registers and result register
// load and clear transactions complete when accepted; a query scans the table with one
// table read per cycle through the single read port, then passes a drain state and a done
// state that loads the result register once it is free; an empty table or a bad server
// goes straight to the done state. reset clears the entry count, the sequencer, the result
// valid and the current features; table contents stay undefined and need no clearing pass
module masked_max_l1_distance_search
    import mmld_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // input transaction channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ID_W-1:0]    i_task_number,
    input  logic [FEAT_W-1:0]  i_feature_a,
    input  logic [FEAT_W-1:0]  i_feature_b,
    input  logic [FEAT_W-1:0]  i_feature_c,
    input  logic [FEAT_W-1:0]  i_feature_d,
    input  logic [MASK_W-1:0]  i_seen_mask,
    input  logic               i_poisoned,
    input  logic [SRV_W-1:0]   i_server_number,

    // result transaction channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [ID_W-1:0]    o_best_task,
    output logic [DIST_W-1:0]  o_best_distance,

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // state and control
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;     // number of stored entries
    logic [CW-1:0]     r_idx;       // next entry to read during a scan
    logic              r_rd_vld;    // table read data is valid this cycle
    logic              r_out_valid;

    // query context and running best
    logic [SRV_W-1:0]  r_srv_idx;   // server number minus one, mask bit index
    logic              r_found;
    logic [ID_W-1:0]   r_best_id;
    logic [DIST_W-1:0] r_best_dist;

    // result register
    logic              r_o_found;
    logic [ID_W-1:0]   r_o_task;
    logic [DIST_W-1:0] r_o_dist;

    // current features from the configuration port
    t_feats            r_cur;

    logic              in_fire;
    logic              cfg_wr;
    logic              srv_ok;
    logic              scan_last;
    logic              tbl_full;
    logic              wr_en;
    logic              rd_en;
    logic              res_load;
    logic              take_entry;
    t_entry            wr_data;
    t_entry            rd_data;
    logic [DIST_W-1:0] ent_dist;

    assign in_fire   = i_in_valid && o_in_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign tbl_full  = (r_count == CW'(TABLE_DEPTH));
    assign scan_last = ((r_idx + CW'(1)) == r_count);

    // server must name a mask bit and exist in the system
    assign srv_ok = (i_server_number != '0)
        && (32'(i_server_number) <= SERVER_COUNT)
        && (32'(i_server_number) <= MASK_W);

    // loads land at the end of the table unless it is full
    assign wr_en = in_fire && (i_func == FUNC_LOAD) && !tbl_full;

    always_comb begin
        wr_data.id    = i_task_number;
        wr_data.feats = {i_feature_d, i_feature_c, i_feature_b, i_feature_a};
        wr_data.seen  = i_seen_mask;
        wr_data.bad   = i_poisoned;
    end

    mmld_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // the shared distance unit sees one entry per cycle
    mmld_dist u_dist (
        .i_cur   (r_cur),
        .i_feats (rd_data.feats),
        .o_dist  (ent_dist)
    );

    // eligible entry that beats the running best; strict compare keeps the earliest tie
    assign take_entry = r_rd_vld && !rd_data.bad && !rd_data.seen[r_srv_idx]
        && (!r_found || (ent_dist > r_best_dist));

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        res_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire && (i_func == FUNC_QUERY)) begin
                    if (srv_ok && (r_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read data is compared this cycle
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    res_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // entry count, scan index and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= rd_en;
            if (in_fire) begin
                case (i_func)
                    FUNC_LOAD: begin
                        if (!tbl_full) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    FUNC_CLEAR: begin
                        r_count <= '0;
                    end
                    FUNC_QUERY: begin
                        r_idx <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    // running best over the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (in_fire && (i_func == FUNC_QUERY)) begin
            r_found <= 1'b0;
        end else if (take_entry) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_func == FUNC_QUERY)) begin
            r_srv_idx   <= i_server_number - SRV_W'(1);
            r_best_id   <= '0;
            r_best_dist <= '0;
        end else if (take_entry) begin
            r_best_id   <= rd_data.id;
            r_best_dist <= ent_dist;
        end
    end

    // result register, holds until the transaction goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_o_found <= r_found;
            r_o_task  <= r_found ? r_best_id : '0;
            r_o_dist  <= r_found ? r_best_dist : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_o_found;
    assign o_best_task     = r_o_task;
    assign o_best_distance = r_o_dist;

    // current feature registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FEAT_A: r_cur[0] <= pwdata[FEAT_W-1:0];
                REG_FEAT_B: r_cur[1] <= pwdata[FEAT_W-1:0];
                REG_FEAT_C: r_cur[2] <= pwdata[FEAT_W-1:0];
                REG_FEAT_D: r_cur[3] <= pwdata[FEAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FEAT_A: prdata = APB_DW'(r_cur[0]);
            REG_FEAT_B: prdata = APB_DW'(r_cur[1]);
            REG_FEAT_C: prdata = APB_DW'(r_cur[2]);
            REG_FEAT_D: prdata = APB_DW'(r_cur[3]);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // checks

    // read data only ever follows a scan cycle
    a_rd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ($past(r_state) == ST_SCAN))
        else $error("table read data without a scan cycle");

    // scan never reads past the stored entries
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx < r_count))
        else $error("scan index beyond entry count");

    // entry count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // an empty answer carries zero id and distance
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> ((o_best_task == '0) && (o_best_distance == '0)))
        else $error("not-found result with nonzero payload");

endmodule

// ===== test/testbench.sv =====
// self-checking bench for the masked max l1 distance search: directed table, full table, random
`timescale 1ns / 1ps

module testbench
    import mmld_pkg::*;
();

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 8_000_000;
    localparam int RANDOM_ITEMS = 580;
    localparam int PHASES       = 6;
    localparam int SETTLE       = 8;
    // soft cap that keeps most scans short during the random part
    localparam int SOFT_FILL    = 48;
    // the one func code the block has no use for
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // one input transaction, all fields carried whatever the func
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   id;
        t_feats            feats;
        logic [MASK_W-1:0] seen;
        logic              bad;
        logic [SRV_W-1:0]  server;
    } t_request;

    // one result transaction
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   task_id;
        logic [DIST_W-1:0] distance;
    } t_answer;

    // directed row: typed answers only where they are obvious
    typedef struct {
        t_request req;
        bit       typed;
        t_answer  want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               i_in_valid;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func;
    logic [ID_W-1:0]    i_task_number;
    logic [FEAT_W-1:0]  i_feature_a;
    logic [FEAT_W-1:0]  i_feature_b;
    logic [FEAT_W-1:0]  i_feature_c;
    logic [FEAT_W-1:0]  i_feature_d;
    logic [MASK_W-1:0]  i_seen_mask;
    logic               i_poisoned;
    logic [SRV_W-1:0]   i_server_number;

    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_found;
    logic [ID_W-1:0]    o_best_task;
    logic [DIST_W-1:0]  o_best_distance;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // shadow copy of the table and of the current feature registers
    t_entry      shadow_table [DEPTH];
    int unsigned shadow_count;
    t_feats      current_feats;

    // answers owed by the block, oldest first
    t_answer owed_answers [$];

    // both sides skip their idle draws while this is set
    bit calm;

    int errors;
    int cycles;
    int n_load, n_query, n_clear, n_spare, n_checked, n_writes;

    masked_max_l1_distance_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_task_number   (i_task_number),
        .i_feature_a     (i_feature_a),
        .i_feature_b     (i_feature_b),
        .i_feature_c     (i_feature_c),
        .i_feature_d     (i_feature_d),
        .i_seen_mask     (i_seen_mask),
        .i_poisoned      (i_poisoned),
        .i_server_number (i_server_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_best_task     (o_best_task),
        .o_best_distance (o_best_distance),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d answers still owed",
                     cycles, owed_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // summed absolute difference to the current features, kept to 9 bits
    function automatic logic [DIST_W-1:0] distance_to_current(input t_feats f);
        int sum;
        int diff;
        int k;
        sum = 0;
        for (k = 0; k < FEATURE_COUNT; k++) begin
            diff = int'(current_feats[k]) - int'(f[k]);
            sum += (diff < 0) ? -diff : diff;
        end
        return DIST_W'(sum);
    endfunction

    // earliest clean, unseen entry with the largest distance for one server
    function automatic t_answer best_unseen_task(input logic [SRV_W-1:0] srv);
        t_answer           best;
        logic [DIST_W-1:0] d;
        int                i;
        best = '0;
        // server 0 or beyond the mask has no bit: nothing is eligible
        if (srv >= 1 && srv <= SERVER_COUNT && srv <= MASK_W) begin
            for (i = 0; i < shadow_count; i++) begin
                if (!shadow_table[i].bad && !shadow_table[i].seen[srv - 1]) begin
                    d = distance_to_current(shadow_table[i].feats);
                    // strict compare keeps the earliest of equal distances
                    if (!best.found || d > best.distance) begin
                        best.found    = 1'b1;
                        best.task_id  = shadow_table[i].id;
                        best.distance = d;
                    end
                end
            end
        end
        return best;
    endfunction

    // update the shadow state for an accepted transaction
    function automatic void absorb_request(input t_request r, input bit typed,
                                           input t_answer want);
        case (r.func)
            FUNC_LOAD: begin
                n_load++;
                // loads into a full table are dropped
                if (shadow_count < DEPTH) begin
                    shadow_table[shadow_count] =
                        '{id: r.id, feats: r.feats, seen: r.seen, bad: r.bad};
                    shadow_count++;
                end
            end
            FUNC_QUERY: begin
                n_query++;
                owed_answers = {owed_answers, typed ? want : best_unseen_task(r.server)};
            end
            FUNC_CLEAR: begin
                n_clear++;
                shadow_count = 0;
            end
            default: n_spare++;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next call decides whether it drops
    task automatic send_request(input t_request r, input bit typed, input t_answer want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_func          = r.func;
        i_task_number   = r.id;
        i_feature_a     = r.feats[0];
        i_feature_b     = r.feats[1];
        i_feature_c     = r.feats[2];
        i_feature_d     = r.feats[3];
        i_seen_mask     = r.seen;
        i_poisoned      = r.bad;
        i_server_number = r.server;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_request(r, typed, want);
        @(negedge i_clk);
    endtask

    // hold the sender until every owed answer is back, then let the block settle
    task automatic wait_quiet(input int settle);
        i_in_valid = 1'b0;
        while (owed_answers.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // random transaction; loads and queries dominate, clears keep scans short
    function automatic t_request random_request();
        t_request r;
        int       pick;
        int       k;
        r.id = ID_W'($urandom);
        for (k = 0; k < FEAT_SLOTS; k++)
            r.feats[k] = ($urandom_range(0, 4) == 0) ? FEAT_W'($urandom_range(0, 127))
                                                     : FEAT_W'($urandom_range(0, 100));
        case ($urandom_range(0, 3))
            0: r.seen = MASK_W'($urandom);
            1: r.seen = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            2: r.seen = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
            default: r.seen = MASK_W'($urandom) & MASK_W'($urandom);
        endcase
        r.bad = ($urandom_range(0, 6) == 0);
        // mostly real servers, now and then 0 or a number past the mask
        pick = $urandom_range(0, 11);
        r.server = ($urandom_range(0, 6) == 0) ? SRV_W'((pick == 0) ? 0 : MASK_W + pick)
                                               : SRV_W'($urandom_range(1, SERVER_COUNT));
        pick = $urandom_range(0, 99);
        if (shadow_count >= SOFT_FILL && $urandom_range(0, 3) == 0)
            r.func = FUNC_CLEAR;
        else if (pick < 55)
            r.func = FUNC_LOAD;
        else if (pick < 90)
            r.func = FUNC_QUERY;
        else if (pick < 94)
            r.func = FUNC_CLEAR;
        else
            r.func = FUNC_SPARE;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------

    // one setup + access transfer, called and returning at a falling edge
    task automatic apb_xfer(input bit wr, input t_reg_idx idx, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read every feature register back against the shadow copy
    task automatic check_features();
        logic [APB_DW-1:0] rd;
        t_reg_idx          idx;
        int                i;
        for (i = 0; i < FEAT_SLOTS; i++) begin
            idx = t_reg_idx'(i);
            apb_xfer(1'b0, idx, '0, rd);
            if (rd !== APB_DW'(current_feats[i])) begin
                $error("register %s: expected %0d, got %0d",
                       idx.name(), current_feats[i], rd);
                errors++;
            end
        end
    endtask

    task automatic program_features(input t_feats v);
        logic [APB_DW-1:0] rd;
        int                i;
        for (i = 0; i < FEAT_SLOTS; i++) begin
            apb_xfer(1'b1, t_reg_idx'(i), APB_DW'(v[i]), rd);
            current_feats[i] = v[i];
            n_writes++;
        end
        check_features();
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------

    // receiver: a drawn stall before each result, ready held until one is taken
    initial begin
        int stall;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // scoreboard: every taken result against the oldest owed answer
    always @(posedge i_clk) begin : result_check
        t_answer due;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (owed_answers.size() == 0) begin
                $error("result with nothing owed: found %0d task %0h distance %0d",
                       o_found, o_best_task, o_best_distance);
                errors++;
            end else begin
                due = owed_answers.pop_front();
                n_checked++;
                if (o_found !== due.found) begin
                    $error("found: expected %0d, got %0d", due.found, o_found);
                    errors++;
                end
                if (o_best_task !== due.task_id) begin
                    $error("best_task: expected %0h, got %0h", due.task_id, o_best_task);
                    errors++;
                end
                if (o_best_distance !== due.distance) begin
                    $error("best_distance: expected %0d, got %0d",
                           due.distance, o_best_distance);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // directed rows
    // ---------------------------------------------------------------

    function automatic t_row row_load(input logic [ID_W-1:0] id, input t_feats f,
                                      input logic [MASK_W-1:0] seen, input logic bad);
        t_row row;
        row = '{req: '0, typed: 1'b0, want: '0};
        row.req.func  = FUNC_LOAD;
        row.req.id    = id;
        row.req.feats = f;
        row.req.seen  = seen;
        row.req.bad   = bad;
        return row;
    endfunction

    function automatic t_row row_plain(input logic [FUNC_W-1:0] func);
        t_row row;
        row = '{req: '0, typed: 1'b0, want: '0};
        row.req.func = func;
        return row;
    endfunction

    // query row; typed rows carry their answer, the others go to the predictor
    function automatic t_row row_query(input logic [SRV_W-1:0] srv, input bit typed,
                                       input t_answer want);
        t_row row;
        row = '{req: '0, typed: typed, want: want};
        row.req.func   = FUNC_QUERY;
        row.req.server = srv;
        return row;
    endfunction

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        t_row     plan [$];
        t_request r;
        t_feats   setting;
        int       counted;
        int       goal;
        int       p;
        int       i;
        int       k;

        // every input known from time zero
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FUNC_LOAD;
        i_task_number   = '0;
        i_feature_a     = '0;
        i_feature_b     = '0;
        i_feature_c     = '0;
        i_feature_d     = '0;
        i_seen_mask     = '0;
        i_poisoned      = 1'b0;
        i_server_number = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        calm            = 1'b0;
        errors          = 0;
        cycles          = 0;
        n_load = 0; n_query = 0; n_clear = 0; n_spare = 0; n_checked = 0; n_writes = 0;
        shadow_count    = 0;
        current_feats   = '0;

        // synchronous reset, released on a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // current features must come out of reset as zero
        check_features();

        // directed table, current features all zero
        // query on an empty table right after reset
        plan = {plan, row_query(5'd1, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        // unused func code: no result
        plan = {plan, row_plain(FUNC_SPARE)};
        // features past one hundred, largest possible distance
        plan = {plan, row_load(16'hFFFF, {4{7'd127}}, 20'h00000, 1'b0)};
        plan = {plan, row_load(16'h0000, {4{7'd0}}, 20'h00000, 1'b0)};
        plan = {plan, row_query(5'd1, 1'b1,
                                '{found: 1'b1, task_id: 16'hFFFF, distance: 9'd508})};
        // servers with no mask bit answer not found
        plan = {plan, row_query(5'd0, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        plan = {plan, row_query(5'd21, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        plan = {plan, row_query(5'd31, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        // seen by every server, poisoned at full distance, and a later tie
        plan = {plan, row_load(16'h1234, {4{7'd100}}, 20'hFFFFF, 1'b0)};
        plan = {plan, row_load(16'hABCD, {4{7'd127}}, 20'h00000, 1'b1)};
        plan = {plan, row_load(16'h0001, {4{7'd127}}, 20'h00001, 1'b0)};
        // tie goes to the earliest loaded entry
        plan = {plan, row_query(5'd20, 1'b1,
                                '{found: 1'b1, task_id: 16'hFFFF, distance: 9'd508})};
        // clear empties the table
        plan = {plan, row_plain(FUNC_CLEAR)};
        plan = {plan, row_query(5'd5, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        // zero distance still counts as found; top mask bit hides it from server 20
        plan = {plan, row_load(16'h0042, {4{7'd0}}, 20'h80000, 1'b0)};
        plan = {plan, row_query(5'd1, 1'b1,
                                '{found: 1'b1, task_id: 16'h0042, distance: 9'd0})};
        plan = {plan, row_query(5'd20, 1'b1, '{found: 1'b0, task_id: '0, distance: '0})};
        // equal distances, the first one masked for server 5
        plan = {plan, row_load(16'h0100, {7'd0, 7'd100, 7'd0, 7'd100}, 20'h00010, 1'b0)};
        plan = {plan, row_load(16'h0200, {7'd100, 7'd0, 7'd100, 7'd0}, 20'h00000, 1'b0)};
        plan = {plan, row_query(5'd5, 1'b1,
                                '{found: 1'b1, task_id: 16'h0200, distance: 9'd200})};
        plan = {plan, row_query(5'd1, 1'b1,
                                '{found: 1'b1, task_id: 16'h0100, distance: 9'd200})};
        // mixed content, left to the predictor
        plan = {plan, row_load(16'h5A5A, {7'd99, 7'd1, 7'd64, 7'd33}, 20'hAAAAA, 1'b0)};
        plan = {plan, row_query(5'd2, 1'b0, '0)};
        plan = {plan, row_query(5'd3, 1'b0, '0)};
        plan = {plan, row_plain(FUNC_CLEAR)};

        foreach (plan[i])
            send_request(plan[i].req, plan[i].typed, plan[i].want);
        wait_quiet(SETTLE);

        // full table: fill every slot, the last with a lone near-maximum, then
        // push loads that would beat it if they were not dropped
        program_features('0);
        for (i = 0; i <= DEPTH + 2; i++) begin
            if (i % 64 == 0)
                calm = $urandom_range(0, 1);
            r = random_request();
            r.func = FUNC_LOAD;
            for (k = 0; k < FEAT_SLOTS; k++)
                r.feats[k] = FEAT_W'($urandom_range(0, 100));
            if (i == DEPTH - 1) begin
                r.id    = 16'hBEEF;
                r.feats = {7'd126, 7'd127, 7'd127, 7'd127};
                r.seen  = '0;
                r.bad   = 1'b0;
            end else if (i >= DEPTH) begin
                r.id    = 16'hDEAD;
                r.feats = {4{7'd127}};
                r.seen  = '0;
                r.bad   = 1'b0;
            end
            send_request(r, 1'b0, '0);
        end
        calm = 1'b0;
        r = random_request();
        r.func = FUNC_QUERY;
        for (i = 0; i < 4; i++) begin
            r.server = (i == 0) ? SRV_W'(1) : (i == 1) ? SRV_W'(SERVER_COUNT)
                     : (i == 2) ? SRV_W'($urandom_range(2, SERVER_COUNT - 1)) : SRV_W'(0);
            send_request(r, 1'b0, '0);
        end
        r.func = FUNC_CLEAR;
        send_request(r, 1'b0, '0);
        wait_quiet(SETTLE);

        // random part: one feature setting per phase, extremes first
        counted = 0;
        for (p = 0; p < PHASES; p++) begin
            wait_quiet(SETTLE);
            if (p == 0)
                setting = {FEAT_SLOTS{FEAT_W'(100)}};
            else if (p == 1)
                setting = '1;
            else if (p == 2)
                setting = '0;
            else
                for (k = 0; k < FEAT_SLOTS; k++)
                    setting[k] = ($urandom_range(0, 3) == 0) ? FEAT_W'($urandom_range(0, 127))
                                                             : FEAT_W'($urandom_range(0, 100));
            program_features(setting);
            goal = RANDOM_ITEMS * (p + 1) / PHASES;
            while (counted < goal) begin
                // stretches with and without idling on both sides
                if ($urandom_range(0, 24) == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // now and then the sender holds until the block has answered everything
                if ($urandom_range(0, 39) == 0)
                    wait_quiet(0);
                r = random_request();
                send_request(r, 1'b0, '0);
                if (r.func != FUNC_SPARE)
                    counted++;
            end
        end
        calm = 1'b0;

        // drain, then watch a while longer for stray results
        wait_quiet(4 * SETTLE);

        $display("covered %0d loads, %0d queries (%0d results checked), %0d clears, %0d spare codes",
                 n_load, n_query, n_checked, n_clear, n_spare);
        $display("one full table of %0d entries, %0d register writes over %0d feature settings",
                 DEPTH, n_writes, PHASES + 1);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
